[hdl/cpcr_pkg.sv]
package cpcr_pkg;

	localparam int FRAC_BITS = 14;
	localparam int GUARD_BITS = 16;
	// divider geometry: divisor bits, quotient bits (one quotient bit per stage)
	localparam int DIV_DW = 33;
	localparam int DIV_QW = 34;
	localparam int DIV_NW = DIV_DW + DIV_QW;
	// start to done, in cycles
	localparam int LAT = 10 + 2 * DIV_QW;

	typedef struct packed {
		logic signed [15:0] first_pos_x;
		logic signed [15:0] first_pos_y;
		logic signed [15:0] first_vel_x;
		logic signed [15:0] first_vel_y;
		logic [14:0] first_radius;
		logic signed [15:0] second_pos_x;
		logic signed [15:0] second_pos_y;
		logic signed [15:0] second_vel_x;
		logic signed [15:0] second_vel_y;
		logic [14:0] second_radius;
	} req_t;

	typedef struct packed {
		logic signed [15:0] first_new_vel_x;
		logic signed [15:0] first_new_vel_y;
		logic signed [15:0] second_new_vel_x;
		logic signed [15:0] second_new_vel_y;
		logic hit;
	} rsp_t;

	// one restoring-division stage: partial remainder and dividend/quotient shifter
	typedef struct packed {
		logic [DIV_DW-1:0] rem;
		logic [DIV_QW-1:0] nq;
	} div_t;

	// values that ride along the pipeline
	typedef struct packed {
		logic signed [15:0] v1x;
		logic signed [15:0] v1y;
		logic signed [15:0] v2x;
		logic signed [15:0] v2y;
		logic [14:0] r1;
		logic [14:0] r2;
		logic [15:0] rs;
		logic hit;
		logic in1;
		logic in2;
		logic [3:0] neg;
	} side_t;

	function automatic div_t div_load(logic [DIV_NW-1:0] n);
		div_t r;
		r.rem = n[DIV_NW-1:DIV_QW];
		r.nq = n[DIV_QW-1:0];
		return r;
	endfunction

	function automatic div_t div_step(div_t a, logic [DIV_DW-1:0] d);
		logic [DIV_DW:0] t;
		div_t r;
		logic qb;
		t = {a.rem, a.nq[DIV_QW-1]};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
			qb = 1'b1;
		end else begin
			qb = 1'b0;
		end
		r.rem = t[DIV_DW-1:0];
		r.nq = {a.nq[DIV_QW-2:0], qb};
		return r;
	endfunction

	// strictly inside the open square (-1, 1) x (-1, 1)
	function automatic logic inside_sq(logic signed [15:0] px, logic signed [15:0] py,
			logic [14:0] r);
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] rr;
		logic signed [17:0] one;
		x = 18'(px);
		y = 18'(py);
		rr = $signed({3'b000, r});
		one = 18'sd1 <<< FRAC_BITS;
		return (x + rr < one) && (x - rr > -one) && (y + rr < one) && (y - rr > -one);
	endfunction

	function automatic logic signed [15:0] sat16(logic signed [36:0] v);
		if (v > 37'sd32767) begin
			return 16'sh7fff;
		end else if (v < -37'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

[hdl/circle_pair_collision_response_core.sv]
// Circle pair collision response. A request is taken on every clock where start is
// high; busy is always low, so a new pair may follow every cycle. The answer comes
// out after passing the stage registers and both dividers, marked by a one-cycle done
// strobe, in request order; the receiver cannot stall. The depth is set by two
// one-bit-per-stage restoring dividers: the first divides n_c*s*2^16 by |n|^2
// (x and y lanes), the second divides by the radius sum (four velocity lanes).
// hit is 1 when the first circle's next center lies within r1+r2 of the second
// center, with coinciding centers or zero radii giving no hit. On a hit each
// circle whose disk sits strictly inside (-1,1)^2 gets its velocity replaced,
// saturated to Q2.14; otherwise velocities pass through unchanged.
module circle_pair_collision_response_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cpcr_pkg::req_t req,
	output logic done,
	output cpcr_pkg::rsp_t rsp
);
	import cpcr_pkg::*;

	// valid chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s7, vld_s8;
	logic vld_d1 [0:DIV_QW];
	logic vld_d2 [0:DIV_QW];

	// stage 1: request capture
	req_t req_s1;

	// stage 2: differences, square tests
	logic signed [16:0] nx_s2, ny_s2, dvx_s2, dvy_s2;
	logic signed [17:0] dx_s2, dy_s2;
	side_t sb_s2;

	// stage 3: products
	logic signed [35:0] dx2_s3, dy2_s3;
	logic signed [33:0] nx2_s3, ny2_s3, ndvx_s3, ndvy_s3;
	logic [31:0] rr_s3;
	logic signed [16:0] nx_s3, ny_s3;
	side_t sb_s3;

	// stage 4: sums and hit test
	logic [32:0] l2_s4;
	logic signed [34:0] s_s4;
	logic signed [16:0] nx_s4, ny_s4;
	side_t sb_s4;

	// stage 5: numerators n_c * s
	logic signed [51:0] num_s5 [0:1];
	logic [32:0] l2_s5;
	side_t sb_s5;

	// first divider, index = stage
	div_t d1_s [0:DIV_QW][0:1];
	logic [DIV_DW-1:0] l2_d1 [0:DIV_QW];
	side_t sb_d1 [0:DIV_QW];

	// stage 7/8: signed quotients and mass scaling
	logic signed [35:0] q_s7 [0:3];
	side_t sb_s7;
	logic signed [52:0] m_s8 [0:3];
	side_t sb_s8;

	// second divider
	div_t d2_s [0:DIV_QW][0:3];
	side_t sb_d2 [0:DIV_QW];

	// combinational stage helpers
	logic [51:0] mag6 [0:1];
	logic signed [35:0] qa7 [0:1];
	logic signed [35:0] qc7 [0:1];
	logic signed [36:0] y9 [0:3];
	logic [36:0] mag9 [0:3];
	logic signed [35:0] qa10 [0:3];
	logic signed [35:0] d10 [0:3];
	logic signed [15:0] vin10 [0:3];
	logic signed [15:0] vnew10 [0:3];
	side_t sb4_c;
	side_t sbd1_c;
	side_t sbd2_c;

	assign busy = 1'b0;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mag6[i] = num_s5[i][51] ? 52'(-num_s5[i]) : 52'(num_s5[i]);
		end
	end

	// floor on a negative numerator: -(Q + (R != 0)); the second circle sees -s
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			qa7[i] = $signed({2'b00, d1_s[DIV_QW][i].nq});
			qc7[i] = -(qa7[i] + 36'(|d1_s[DIV_QW][i].rem));
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			y9[i] = m_s8[i][52:GUARD_BITS];
			mag9[i] = y9[i][36] ? 37'(-y9[i]) : 37'(y9[i]);
		end
	end

	// sideband with the fields that change at stage entry
	always_comb begin
		sb4_c = sb_s3;
		sb4_c.hit = (sb_s3.rs != '0) && (nx_s3 != '0 || ny_s3 != '0)
			&& ((36'(dx2_s3[33:0]) + 36'(dy2_s3[33:0])) <= 36'(rr_s3));
		sbd1_c = sb_s5;
		sbd1_c.neg = {2'b00, num_s5[1][51], num_s5[0][51]};
		sbd2_c = sb_s8;
		sbd2_c.neg = {y9[3][36], y9[2][36], y9[1][36], y9[0][36]};
	end

	always_comb begin
		vin10[0] = sb_d2[DIV_QW].v1x;
		vin10[1] = sb_d2[DIV_QW].v1y;
		vin10[2] = sb_d2[DIV_QW].v2x;
		vin10[3] = sb_d2[DIV_QW].v2y;
		for (int i = 0; i < 4; i++) begin
			qa10[i] = $signed({2'b00, d2_s[DIV_QW][i].nq});
			d10[i] = sb_d2[DIV_QW].neg[i] ?
				-(qa10[i] + 36'(|d2_s[DIV_QW][i].rem)) : qa10[i];
			if (sb_d2[DIV_QW].hit && (i < 2 ? sb_d2[DIV_QW].in1 : sb_d2[DIV_QW].in2)) begin
				vnew10[i] = sat16(37'(vin10[i]) + 37'(d10[i]));
			end else begin
				vnew10[i] = vin10[i];
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			for (int k = 0; k <= DIV_QW; k++) begin
				vld_d1[k] <= 1'b0;
				vld_d2[k] <= 1'b0;
			end
			done <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_d1[0] <= vld_s5;
			for (int k = 0; k < DIV_QW; k++) begin
				vld_d1[k+1] <= vld_d1[k];
				vld_d2[k+1] <= vld_d2[k];
			end
			vld_s7 <= vld_d1[DIV_QW];
			vld_s8 <= vld_s7;
			vld_d2[0] <= vld_s8;
			done <= vld_d2[DIV_QW];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end

		// stage 2
		nx_s2 <= 17'(req_s1.second_pos_x) - 17'(req_s1.first_pos_x);
		ny_s2 <= 17'(req_s1.second_pos_y) - 17'(req_s1.first_pos_y);
		dx_s2 <= 18'(req_s1.second_pos_x) - 18'(req_s1.first_pos_x)
			- 18'(req_s1.first_vel_x);
		dy_s2 <= 18'(req_s1.second_pos_y) - 18'(req_s1.first_pos_y)
			- 18'(req_s1.first_vel_y);
		dvx_s2 <= 17'(req_s1.second_vel_x) - 17'(req_s1.first_vel_x);
		dvy_s2 <= 17'(req_s1.second_vel_y) - 17'(req_s1.first_vel_y);
		sb_s2.v1x <= req_s1.first_vel_x;
		sb_s2.v1y <= req_s1.first_vel_y;
		sb_s2.v2x <= req_s1.second_vel_x;
		sb_s2.v2y <= req_s1.second_vel_y;
		sb_s2.r1 <= req_s1.first_radius;
		sb_s2.r2 <= req_s1.second_radius;
		sb_s2.rs <= 16'(req_s1.first_radius) + 16'(req_s1.second_radius);
		sb_s2.hit <= 1'b0;
		sb_s2.in1 <= inside_sq(req_s1.first_pos_x, req_s1.first_pos_y,
			req_s1.first_radius);
		sb_s2.in2 <= inside_sq(req_s1.second_pos_x, req_s1.second_pos_y,
			req_s1.second_radius);
		sb_s2.neg <= '0;

		// stage 3
		dx2_s3 <= dx_s2 * dx_s2;
		dy2_s3 <= dy_s2 * dy_s2;
		nx2_s3 <= nx_s2 * nx_s2;
		ny2_s3 <= ny_s2 * ny_s2;
		ndvx_s3 <= nx_s2 * dvx_s2;
		ndvy_s3 <= ny_s2 * dvy_s2;
		rr_s3 <= 32'(sb_s2.rs) * 32'(sb_s2.rs);
		nx_s3 <= nx_s2;
		ny_s3 <= ny_s2;
		sb_s3 <= sb_s2;

		// stage 4: squared-distance test
		l2_s4 <= 33'(nx2_s3[31:0]) + 33'(ny2_s3[31:0]);
		s_s4 <= 35'(ndvx_s3) + 35'(ndvy_s3);
		nx_s4 <= nx_s3;
		ny_s4 <= ny_s3;
		sb_s4 <= sb4_c;

		// stage 5
		num_s5[0] <= 52'(nx_s4) * 52'(s_s4);
		num_s5[1] <= 52'(ny_s4) * 52'(s_s4);
		l2_s5 <= l2_s4;
		sb_s5 <= sb_s4;

		// first divider entry: |num| * 2^16 / l2
		for (int i = 0; i < 2; i++) begin
			d1_s[0][i] <= div_load({mag6[i][50:0], {GUARD_BITS{1'b0}}});
		end
		l2_d1[0] <= l2_s5;
		sb_d1[0] <= sbd1_c;

		for (int k = 0; k < DIV_QW; k++) begin
			for (int i = 0; i < 2; i++) begin
				d1_s[k+1][i] <= div_step(d1_s[k][i], l2_d1[k]);
			end
			l2_d1[k+1] <= l2_d1[k];
			sb_d1[k+1] <= sb_d1[k];
			for (int i = 0; i < 4; i++) begin
				d2_s[k+1][i] <= div_step(d2_s[k][i], DIV_DW'(sb_d2[k].rs));
			end
			sb_d2[k+1] <= sb_d2[k];
		end

		// stage 7: lanes 0/1 first circle x/y, 2/3 second circle x/y
		for (int i = 0; i < 2; i++) begin
			q_s7[i] <= sb_d1[DIV_QW].neg[i] ? qc7[i] : qa7[i];
			q_s7[i+2] <= sb_d1[DIV_QW].neg[i] ? qa7[i] : qc7[i];
		end
		sb_s7 <= sb_d1[DIV_QW];

		// stage 8: times 2 * other mass
		for (int i = 0; i < 4; i++) begin
			m_s8[i] <= 53'(q_s7[i])
				* 53'($signed({1'b0, (i < 2) ? sb_s7.r2 : sb_s7.r1, 1'b0}));
		end
		sb_s8 <= sb_s7;

		// second divider entry: floor(m / 2^16) / rs
		for (int i = 0; i < 4; i++) begin
			d2_s[0][i] <= div_load(DIV_NW'(mag9[i]));
		end
		sb_d2[0] <= sbd2_c;

		// output register
		rsp.first_new_vel_x <= vnew10[0];
		rsp.first_new_vel_y <= vnew10[1];
		rsp.second_new_vel_x <= vnew10[2];
		rsp.second_new_vel_y <= vnew10[3];
		rsp.hit <= sb_d2[DIV_QW].hit;
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request did not complete after fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("done without matching request");

	a_miss_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.hit) |-> (rsp.first_new_vel_x == $past(req.first_vel_x, LAT)
			&& rsp.second_new_vel_y == $past(req.second_vel_y, LAT)))
		else $error("velocity changed without a hit");
`endif

endmodule
